### rtl/reader_response_frame_checker_macros.svh
// Assertion macros for the reader response frame checker.
`ifndef READER_RESPONSE_FRAME_CHECKER_MACROS_SVH
`define READER_RESPONSE_FRAME_CHECKER_MACROS_SVH
`ifndef ASSERT_OFF
`define RRFC_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define RRFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RRFC_ASSERT_IMPL(label, clk, rst_n, prop)
`define RRFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rrfc_pkg.sv
// Shared types and constants for the reader response frame checker.
package rrfc_pkg;
	localparam int unsigned MinFrameBytes = 6;

	typedef enum logic [1:0] {
		CMD_BYTE   = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_CANCEL = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		VERDICT_MATCHED   = 3'd0,
		VERDICT_ACTIVE    = 3'd1,
		VERDICT_IGNORED   = 3'd2,
		VERDICT_MALFORMED = 3'd3,
		VERDICT_TIMEOUT   = 3'd4
	} verdict_e;

	typedef enum logic [2:0] {
		FAULT_NONE      = 3'd0,
		FAULT_SHORT     = 3'd1,
		FAULT_BAD_START = 3'd2,
		FAULT_TRUNCATED = 3'd3,
		FAULT_CHECKSUM  = 3'd4
	} fault_e;

	typedef enum logic [2:0] {
		REG_NORMAL_START = 3'd0,
		REG_ERROR_START  = 3'd1,
		REG_SUCCESS_CODE = 3'd2,
		REG_ACTIVE_BYTE  = 3'd3,
		REG_TIMEOUT      = 3'd4
	} reg_idx_e;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] value;
		logic       packet_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [2:0]  fault_reason;
		logic        error_frame;
		logic [7:0]  command_code;
		logic [7:0]  device_status;
		logic [15:0] data_length;
		logic [7:0]  first_data_byte;
	} out_item_t;

	// Packet summary handed from the byte front end to the verdict stage
	typedef struct packed {
		logic        is_timeout;
		logic [7:0]  timeout_cmd;
		logic        short_pkt;
		logic        is_err;
		logic        is_norm;
		logic        truncated;
		logic        sum_good;
		logic [7:0]  hdr_command;
		logic [15:0] hdr_length;
		logic [7:0]  hdr_first;
	} summary_t;

	typedef struct packed {
		logic [7:0]  normal_start;
		logic [7:0]  error_start;
		logic [7:0]  success_code;
		logic [7:0]  active_byte;
		logic [15:0] timeout_ticks;
	} cfg_t;
endpackage

### rtl/reader_response_frame_checker.sv
// Reader response frame checker.
// Input queue side: item = {command, value, packet_end}, taken when push && !full.
// Received bytes build a frame (start, length at bytes 2-3, command, data, XOR);
// the byte with packet_end yields one verdict. Arm, tick and cancel items run a
// response timeout; a tick past the limit yields a timeout verdict.
// Result queue side: result shown while !empty, taken when pop.
// One item per cycle while full is low. A verdict is written to the result queue at
// the edge that takes its item and can be popped from the cycle after.
// A two-entry result queue decouples the sides; full rises when it holds two
// results, so input stalls only while the receiver stalls.
// Configuration writes (cfg_valid/cfg_ready, always ready) must go in while idle;
// not enforced. Reset clears the packet, wait state and queue; reloads register defaults.
module reader_response_frame_checker #(
	parameter int unsigned PACKET_BUFFER_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rrfc_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output rrfc_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import rrfc_pkg::*;

	`include "reader_response_frame_checker_macros.svh"

	cfg_t      cfg_q;
	logic      take, emit, matched, awaiting, q_full, rd;
	logic [7:0] wait_cmd;
	summary_t  summary;
	out_item_t result;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign take      = push && !q_full;
	assign rd        = pop && !empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_start  <= 8'h60;
			cfg_q.error_start   <= 8'hE0;
			cfg_q.success_code  <= 8'h00;
			cfg_q.active_byte   <= 8'h04;
			cfg_q.timeout_ticks <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NORMAL_START: cfg_q.normal_start  <= cfg_data[7:0];
				REG_ERROR_START:  cfg_q.error_start   <= cfg_data[7:0];
				REG_SUCCESS_CODE: cfg_q.success_code  <= cfg_data[7:0];
				REG_ACTIVE_BYTE:  cfg_q.active_byte   <= cfg_data[7:0];
				REG_TIMEOUT:      cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	rrfc_front #(.PACKET_BUFFER_BYTES(PACKET_BUFFER_BYTES)) u_front (
		.clk, .arst_n, .take, .item(in_item), .cfg(cfg_q),
		.match_clear(emit && matched), .emit, .summary, .awaiting, .wait_cmd
	);

	rrfc_back u_back (
		.summary, .cfg(cfg_q), .awaiting, .wait_cmd, .result, .matched
	);

	rrfc_queue u_queue (
		.clk, .arst_n, .wr(emit), .wdata(result), .rd, .rdata(out_item),
		.empty, .full(q_full)
	);

	`RRFC_ASSERT_IMPL(a_no_emit_unless_take, clk, arst_n, emit |-> take)
	`RRFC_ASSERT_NEXT(a_match_clears_wait, clk, arst_n, emit && matched, !awaiting)
	`RRFC_ASSERT_IMPL(a_match_only_when_waiting, clk, arst_n, (emit && matched) |-> awaiting)
endmodule

### rtl/rrfc_front.sv
// Byte front end: header capture, running XOR and timeout counting.
module rrfc_front #(
	parameter int unsigned PACKET_BUFFER_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  rrfc_pkg::in_item_t item,
	input  rrfc_pkg::cfg_t    cfg,
	input  logic              match_clear,
	output logic              emit,
	output rrfc_pkg::summary_t summary,
	output logic              awaiting,
	output logic [7:0]        wait_cmd
);
	import rrfc_pkg::*;

	localparam int unsigned PosW = $clog2(PACKET_BUFFER_BYTES + 1);

	logic [PosW-1:0] pos_q;
	logic [7:0]      xor_q, start_q, cmd_q, first_q;
	logic [15:0]     len_q;
	logic [1:0]      checked_q;
	logic [7:0]      pend_q;
	logic            await_q;
	logic [16:0]     elapsed_q;

	logic            in_buf;
	logic [15:0]     len_now;
	logic [16:0]     last_pos;
	logic [16:0]     pos_new;
	logic            check_hit;
	logic [1:0]      checked_now;
	logic [7:0]      start_now, cmd_now, first_now;
	logic [16:0]     elapsed_inc;

	// Bytes beyond the buffer are dropped but still end the packet
	always_comb begin
		in_buf      = pos_q < PosW'(PACKET_BUFFER_BYTES);
		len_now     = len_q;
		start_now   = start_q;
		cmd_now     = cmd_q;
		first_now   = first_q;
		if (in_buf) begin
			if (pos_q == PosW'(0)) start_now = item.value;
			if (pos_q == PosW'(2)) len_now = {item.value, len_q[7:0]};
			if (pos_q == PosW'(3)) len_now = {len_q[15:8], item.value};
			if (pos_q == PosW'(4)) cmd_now = item.value;
			if (pos_q == PosW'(5)) first_now = item.value;
		end
		last_pos    = 17'(len_q) + 17'(MinFrameBytes - 1);
		check_hit   = in_buf && pos_q >= PosW'(4) && checked_q == 2'd0 &&
			17'(pos_q) == last_pos;
		checked_now = check_hit ? ((xor_q == item.value) ? 2'd1 : 2'd2) : checked_q;
		pos_new     = in_buf ? 17'(pos_q) + 17'd1 : 17'(pos_q);
		elapsed_inc = (elapsed_q != 17'h1FFFF) ? elapsed_q + 17'd1 : elapsed_q;
	end

	// Summary for the back end
	always_comb begin
		summary             = '0;
		summary.short_pkt   = pos_new < 17'(MinFrameBytes);
		summary.is_err      = start_now == cfg.error_start;
		summary.is_norm     = start_now == cfg.normal_start;
		summary.truncated   = pos_new < 17'(len_now) + 17'(MinFrameBytes);
		summary.sum_good    = checked_now == 2'd1;
		summary.hdr_command = cmd_now;
		summary.hdr_length  = len_now;
		summary.hdr_first   = first_now;
		summary.timeout_cmd = pend_q;
		emit                = 1'b0;
		if (take) begin
			unique case (cmd_t'(item.command))
				CMD_BYTE: emit = item.packet_end;
				CMD_TICK: begin
					emit               = await_q && (elapsed_inc > 17'(cfg.timeout_ticks));
					summary.is_timeout = 1'b1;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	assign awaiting = await_q;
	assign wait_cmd = pend_q;

	// Packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= '0;
			start_q   <= '0;
			len_q     <= '0;
			cmd_q     <= '0;
			first_q   <= '0;
			checked_q <= '0;
		end else if (take && cmd_t'(item.command) == CMD_BYTE) begin
			if (item.packet_end) begin
				pos_q     <= '0;
				xor_q     <= '0;
				start_q   <= '0;
				len_q     <= '0;
				cmd_q     <= '0;
				first_q   <= '0;
				checked_q <= '0;
			end else if (in_buf) begin
				pos_q     <= pos_new[PosW-1:0];
				xor_q     <= xor_q ^ item.value;
				start_q   <= start_now;
				len_q     <= len_now;
				cmd_q     <= cmd_now;
				first_q   <= first_now;
				checked_q <= checked_now;
			end
		end
	end

	// Pending command and timeout counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			await_q   <= 1'b0;
			elapsed_q <= '0;
		end else if (match_clear) begin
			await_q <= 1'b0;
		end else if (take) begin
			unique case (cmd_t'(item.command))
				CMD_ARM: begin
					pend_q    <= item.value;
					await_q   <= 1'b1;
					elapsed_q <= '0;
				end
				CMD_TICK: if (await_q) begin
					elapsed_q <= elapsed_inc;
					if (elapsed_inc > 17'(cfg.timeout_ticks)) await_q <= 1'b0;
				end
				CMD_CANCEL: await_q <= 1'b0;
				default: ;
			endcase
		end
	end
endmodule

### rtl/rrfc_back.sv
// Verdict stage: turns a packet summary into a result item.
module rrfc_back (
	input  rrfc_pkg::summary_t  summary,
	input  rrfc_pkg::cfg_t      cfg,
	input  logic                awaiting,
	input  logic [7:0]          wait_cmd,
	output rrfc_pkg::out_item_t result,
	output logic                matched
);
	import rrfc_pkg::*;

	fault_e reason;

	always_comb begin
		priority if (summary.short_pkt) reason = FAULT_SHORT;
		else if (!summary.is_err && !summary.is_norm) reason = FAULT_BAD_START;
		else if (summary.truncated) reason = FAULT_TRUNCATED;
		else if (!summary.sum_good) reason = FAULT_CHECKSUM;
		else reason = FAULT_NONE;
	end

	always_comb begin
		result  = '0;
		matched = 1'b0;
		if (summary.is_timeout) begin
			result.verdict      = VERDICT_TIMEOUT;
			result.command_code = summary.timeout_cmd;
		end else if (reason != FAULT_NONE) begin
			result.verdict      = VERDICT_MALFORMED;
			result.fault_reason = reason;
		end else begin
			result.error_frame     = summary.is_err;
			result.command_code    = summary.hdr_command;
			result.device_status   = summary.is_err ? summary.hdr_command : cfg.success_code;
			result.data_length     = summary.hdr_length;
			result.first_data_byte = (summary.hdr_length != 16'd0) ? summary.hdr_first : 8'd0;
			priority if (awaiting && summary.hdr_command == wait_cmd) begin
				result.verdict = VERDICT_MATCHED;
				matched        = 1'b1;
			end else if (summary.hdr_length != 16'd0 &&
				summary.hdr_first == cfg.active_byte) begin
				result.verdict = VERDICT_ACTIVE;
			end else begin
				result.verdict = VERDICT_IGNORED;
			end
		end
	end
endmodule

### rtl/rrfc_queue.sv
// Two-entry result queue between verdict stage and the output side.
module rrfc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  rrfc_pkg::out_item_t wdata,
	input  logic                rd,
	output rrfc_pkg::out_item_t rdata,
	output logic                empty,
	output logic                full
);
	import rrfc_pkg::*;

	out_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

### bench/tb_reader_response_frame_checker.sv
// Testbench for the reader response frame checker: directed frames, timeouts and random traffic.
module tb_reader_response_frame_checker;
	timeunit 1ns;
	timeprecision 1ps;
	import rrfc_pkg::*;

	localparam int unsigned BufBytes = 256;
	localparam int unsigned CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t in_item;
	logic empty;
	logic pop;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	reader_response_frame_checker #(.PACKET_BUFFER_BYTES(BufBytes)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of registers and state
	logic [7:0] m_normal, m_error, m_success, m_active;
	logic [15:0] m_timeout;
	int unsigned pos;
	logic [7:0] xsum, h_start, h_cmd, h_first, pend_cmd;
	logic [15:0] h_len;
	logic [1:0] checked;
	logic waiting;
	int unsigned elapsed;

	out_item_t verdict_q[$];
	int unsigned mismatches;
	int unsigned cycles;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic out_item_t make_verdict(verdict_e v, fault_e f, logic e, logic [7:0] c,
			logic [7:0] s, logic [15:0] l, logic [7:0] d);
		out_item_t r;
		r.verdict = v;
		r.fault_reason = f;
		r.error_frame = e;
		r.command_code = c;
		r.device_status = s;
		r.data_length = l;
		r.first_data_byte = d;
		return r;
	endfunction

	function automatic void clear_frame();
		pos = 0;
		xsum = 0;
		h_start = 0;
		h_len = 0;
		h_cmd = 0;
		h_first = 0;
		checked = 0;
	endfunction

	// update the predictor with one accepted request; queue any verdict
	function automatic void predict_verdict(in_item_t it);
		fault_e f;
		logic is_err, is_norm;
		verdict_e v;
		case (cmd_t'(it.command))
			CMD_BYTE: begin
				if (pos < BufBytes) begin
					case (pos)
						0: h_start = it.value;
						2: h_len[15:8] = it.value;
						3: h_len[7:0] = it.value;
						4: h_cmd = it.value;
						5: h_first = it.value;
						default: ;
					endcase
					if (pos >= 4 && checked == 0 && pos == 5 + 32'(h_len))
						checked = (xsum == it.value) ? 2'd1 : 2'd2;
					xsum ^= it.value;
					pos++;
				end
				if (it.packet_end) begin
					is_err = (h_start == m_error);
					is_norm = (h_start == m_normal);
					f = FAULT_NONE;
					if (pos < MinFrameBytes) f = FAULT_SHORT;
					else if (!is_err && !is_norm) f = FAULT_BAD_START;
					else if (pos < MinFrameBytes + 32'(h_len)) f = FAULT_TRUNCATED;
					else if (checked != 1) f = FAULT_CHECKSUM;
					if (f != FAULT_NONE) begin
						verdict_q.push_back(make_verdict(VERDICT_MALFORMED, f, 0, 0, 0, 0, 0));
					end else begin
						if (waiting && h_cmd == pend_cmd) begin
							waiting = 0;
							v = VERDICT_MATCHED;
						end else if (h_len > 0 && h_first == m_active) begin
							v = VERDICT_ACTIVE;
						end else begin
							v = VERDICT_IGNORED;
						end
						verdict_q.push_back(make_verdict(v, FAULT_NONE, is_err, h_cmd,
							is_err ? h_cmd : m_success, h_len, h_len > 0 ? h_first : 8'd0));
					end
					clear_frame();
				end
			end
			CMD_ARM: begin
				pend_cmd = it.value;
				waiting = 1;
				elapsed = 0;
			end
			CMD_TICK: begin
				if (waiting) begin
					if (elapsed < 'h1FFFF) elapsed++;
					if (elapsed > m_timeout) begin
						waiting = 0;
						verdict_q.push_back(make_verdict(VERDICT_TIMEOUT, FAULT_NONE, 0,
							pend_cmd, 0, 0, 0));
					end
				end
			end
			default: waiting = 0;
		endcase
	endfunction

	// result side: random stall bursts and comparison
	initial begin : verdict_checker
		int unsigned stall;
		out_item_t exp_v;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected verdict %p", out_item);
				end else begin
					exp_v = verdict_q.pop_front();
					if (out_item !== exp_v) begin
						mismatches++;
						if (mismatches <= 10)
							$display("verdict mismatch: expected %p got %p", exp_v, out_item);
					end
				end
			end
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 15) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// send one request, with a random idle burst first; push stays high for the next one
	task automatic send_request(cmd_t c, logic [7:0] v, logic e);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= '{command: c, value: v, packet_end: e};
		do @(posedge clk); while (full);
		predict_verdict('{command: c, value: v, packet_end: e});
	endtask

	task automatic drain();
		push <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_e idx, logic [15:0] d);
		push <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_NORMAL_START: m_normal = d[7:0];
			REG_ERROR_START: m_error = d[7:0];
			REG_SUCCESS_CODE: m_success = d[7:0];
			REG_ACTIVE_BYTE: m_active = d[7:0];
			default: m_timeout = d;
		endcase
		@(posedge clk);
	endtask

	// send a frame; corrupt selects a bad checksum, extra adds trailing bytes
	task automatic send_frame(logic [7:0] start, logic [7:0] cmd, int unsigned len,
			logic [7:0] first, bit corrupt, int unsigned extra);
		logic [7:0] bytes[$];
		logic [7:0] x;
		bytes = {start, 8'($urandom), 8'(len >> 8), 8'(len), cmd};
		for (int unsigned i = 0; i < len; i++)
			bytes.push_back(i == 0 ? first : 8'($urandom));
		x = 0;
		foreach (bytes[i]) x ^= bytes[i];
		bytes.push_back(corrupt ? ~x : x);
		repeat (extra) bytes.push_back(8'($urandom));
		foreach (bytes[i]) send_request(CMD_BYTE, bytes[i], i == bytes.size() - 1);
	endtask

	function automatic logic [7:0] pick_start();
		case ($urandom_range(0, 3))
			0: return m_error;
			1: return 8'($urandom);
			default: return m_normal;
		endcase
	endfunction

	task automatic test_directed_frames();
		send_frame(8'h60, 8'h11, 0, 0, 0, 0);           // ignored, empty data
		send_frame(8'h60, 8'h22, 3, 8'h04, 0, 0);       // active card frame
		send_frame(8'hE0, 8'h33, 1, 8'h55, 0, 2);       // error frame, trailing bytes
		send_frame(8'h60, 8'hFF, 2, 8'hFF, 1, 0);       // checksum
		send_frame(8'h12, 8'h00, 0, 0, 0, 0);           // bad start
		send_request(CMD_BYTE, 8'h60, 1);               // under six bytes
		for (int i = 0; i < 5; i++) send_request(CMD_BYTE, 8'hFF, i == 4); // short, ones
		// truncated: length 0xFFFF declared
		send_request(CMD_BYTE, 8'h60, 0);
		send_request(CMD_BYTE, 8'h00, 0);
		send_request(CMD_BYTE, 8'hFF, 0);
		send_request(CMD_BYTE, 8'hFF, 0);
		send_request(CMD_BYTE, 8'h01, 0);
		send_request(CMD_BYTE, 8'h02, 1);
		drain();
	endtask

	task automatic test_long_packet();
		// frame ends at byte 250, trailing bytes run past the buffer
		send_frame(8'h60, 8'h01, 245, 8'h04, 0, 20);
		drain();
	endtask

	task automatic test_timeout_and_match();
		write_reg(REG_TIMEOUT, 16'd1);
		send_request(CMD_TICK, 8'h00, 0);               // not armed, nothing
		send_request(CMD_ARM, 8'hA5, 0);
		send_request(CMD_TICK, 8'h00, 0);
		send_request(CMD_TICK, 8'h00, 1);               // timeout
		send_request(CMD_ARM, 8'h5A, 0);
		send_frame(8'h60, 8'h5A, 1, 8'h04, 0, 0);       // matched over active
		send_request(CMD_ARM, 8'h77, 0);
		send_request(CMD_CANCEL, 8'h00, 0);
		send_request(CMD_TICK, 8'h00, 0);
		send_request(CMD_TICK, 8'h00, 0);
		drain();
		write_reg(REG_TIMEOUT, 16'hFFFF);
		send_request(CMD_ARM, 8'h01, 0);
		send_request(CMD_TICK, 8'h00, 0);
		drain();
	endtask

	task automatic test_registers();
		write_reg(REG_NORMAL_START, 16'h00AA);
		write_reg(REG_ERROR_START, 16'h00AA);          // equal starts count as error
		write_reg(REG_SUCCESS_CODE, 16'h00FF);
		write_reg(REG_ACTIVE_BYTE, 16'h0000);
		send_frame(8'hAA, 8'h10, 1, 8'h00, 0, 0);
		drain();
		write_reg(REG_NORMAL_START, 16'h00FF);
		write_reg(REG_ERROR_START, 16'h0000);
		write_reg(REG_SUCCESS_CODE, 16'h0000);
		write_reg(REG_ACTIVE_BYTE, 16'h00FF);
		send_frame(8'hFF, 8'h10, 1, 8'hFF, 0, 0);
		send_frame(8'h00, 8'hFF, 2, 8'h80, 0, 0);
		drain();
	endtask

	task automatic random_phase(int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					len = $urandom_range(0, 5) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 4);
					if ($urandom_range(0, 3) == 0) send_request(CMD_ARM, 8'($urandom_range(0, 3)), 0);
					send_frame(pick_start(), 8'($urandom_range(0, 3)), len,
						$urandom_range(0, 1) ? m_active : 8'($urandom),
						$urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0 ? 2 : 0);
					sent += len + 6;
				end
				5, 6: begin
					send_request(CMD_TICK, 8'($urandom), 1'($urandom));
					sent++;
				end
				7: begin
					send_request(CMD_ARM, 8'($urandom_range(0, 3)), 1'($urandom));
					sent++;
				end
				8: begin
					send_request(CMD_CANCEL, 8'($urandom), 1'($urandom));
					sent++;
				end
				default: begin
					send_request(CMD_BYTE, 8'($urandom), $urandom_range(0, 3) == 0);
					sent++;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_NORMAL_START;
		cfg_data = '0;
		cycles = 0;
		mismatches = 0;
		quiet = 0;
		m_normal = 8'h60;
		m_error = 8'hE0;
		m_success = 8'h00;
		m_active = 8'h04;
		m_timeout = 16'd1000;
		pend_cmd = 0;
		waiting = 0;
		elapsed = 0;
		clear_frame();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_long_packet();
		test_timeout_and_match();
		test_registers();
		write_reg(REG_NORMAL_START, 16'h0060);
		write_reg(REG_ERROR_START, 16'h00E0);
		write_reg(REG_SUCCESS_CODE, 16'h0042);
		write_reg(REG_ACTIVE_BYTE, 16'h0004);
		write_reg(REG_TIMEOUT, 16'd3);
		random_phase(100);
		drain();
		write_reg(REG_TIMEOUT, 16'd8);
		random_phase(50);
		quiet = 1;
		random_phase(50);
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
